[sv/lpd_pkg.sv]
`timescale 1ns / 1ps

package lpd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEN2   = 2'd1,
    PH_BODY   = 2'd2,
    PH_CLOSED = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MIN_LEN    = 2'd0,
    CFG_MAX_LEN    = 2'd1,
    CFG_BIG_ENDIAN = 2'd2
  } cfg_idx_e;

  localparam logic [1:0]  ST_OK    = 2'd0;
  localparam logic [1:0]  ST_SHORT = 2'd1;
  localparam logic [1:0]  ST_LONG  = 2'd2;

  localparam logic [15:0] LEN_HDR_BYTES   = 16'd2;
  localparam logic [15:0] MIN_LEN_DEFAULT = 16'd2;
  localparam logic [15:0] MAX_LEN_DEFAULT = 16'hFFFF;

  typedef struct packed {
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic        big_endian;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       pkt_start;
    logic       pkt_end;
    logic [1:0] frame_status;
  } frame_t;

endpackage

[sv/lpd_if.sv]
`timescale 1ns / 1ps

interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       pkt_start;
  logic       pkt_end;
  logic [1:0] frame_status;

  modport source (output valid, output out_byte, output pkt_start, output pkt_end,
                  output frame_status, input ready);
  modport sink (input valid, input out_byte, input pkt_start, input pkt_end,
                input frame_status, output ready);
endinterface

interface lpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/lpd_cfg_regs.sv]
`timescale 1ns / 1ps

module lpd_cfg_regs
  import lpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [1:0]  wr_index_i,
  input  logic [15:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_MIN_LEN:    cfg_d.min_len = wr_data_i;
        CFG_MAX_LEN:    cfg_d.max_len = wr_data_i;
        CFG_BIG_ENDIAN: cfg_d.big_endian = wr_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len    <= MIN_LEN_DEFAULT;
      cfg_q.max_len    <= MAX_LEN_DEFAULT;
      cfg_q.big_endian <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/lpd_frame_fsm.sv]
`timescale 1ns / 1ps

module lpd_frame_fsm
  import lpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output frame_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] len;

  // length as seen on the second header byte
  assign len = cfg_i.big_endian ? {first_q, rx_byte_i} : {rx_byte_i, first_q};

  always_comb begin
    phase_d            = phase_q;
    first_d            = first_q;
    remain_d           = remain_q;
    res_valid_o        = 1'b0;
    res_o.out_byte     = rx_byte_i;
    res_o.pkt_start    = 1'b0;
    res_o.pkt_end      = 1'b0;
    res_o.frame_status = ST_OK;
    if (take_i) begin
      case (phase_q)
        PH_IDLE: begin
          first_d         = rx_byte_i;
          phase_d         = PH_LEN2;
          res_valid_o     = 1'b1;
          res_o.pkt_start = 1'b1;
        end
        PH_LEN2: begin
          res_valid_o = 1'b1;
          if (len < LEN_HDR_BYTES || len < cfg_i.min_len) begin
            phase_d            = PH_CLOSED;
            res_o.pkt_end      = 1'b1;
            res_o.frame_status = ST_SHORT;
          end else if (len > cfg_i.max_len) begin
            phase_d            = PH_CLOSED;
            res_o.pkt_end      = 1'b1;
            res_o.frame_status = ST_LONG;
          end else begin
            remain_d = len - LEN_HDR_BYTES;
            if (len == LEN_HDR_BYTES) begin
              phase_d       = PH_IDLE;
              res_o.pkt_end = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          if (remain_q <= 16'd1) begin
            remain_d      = '0;
            phase_d       = PH_IDLE;
            res_o.pkt_end = 1'b1;
          end else begin
            remain_d = remain_q - 16'd1;
          end
        end
        default: begin
          // closed: bytes are swallowed until reset
          phase_d = PH_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      first_q  <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      remain_q <= remain_d;
    end
  end

endmodule

[sv/length_prefixed_byte_deframer.sv]
`timescale 1ns / 1ps

// length prefixed byte deframer
// rx_i carries one received byte per beat; every packet opens with a 16-bit
// total length (header bytes included), low byte first unless the byte order
// register says otherwise
// tx_o gives one beat per packet byte with the byte itself, start/end marks
// and a status; a length out of bounds gives one error beat on the second
// header byte, after which all further input is taken and dropped
// cfg_i writes min length (index 0), max length (1) and byte order (2);
// writes are always accepted, other indexes are ignored
// a byte is registered once and shows on tx_o in the cycle after its beat is accepted
// throughput: one byte per cycle while tx_o is ready, set by the single output register; the
// header decode and body counter finish within that cycle
// a stalled receiver holds the output register, and rx_i still accepts a
// byte in the cycle the held beat is taken
// reset clears the framing state and loads min 2, max 65535, little endian
module length_prefixed_byte_deframer
  import lpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lpd_byte_if.sink    rx_i,
  lpd_frame_if.source tx_o,
  lpd_cfg_if.sink     cfg_i
);

  cfg_t   cfg;
  logic   take;
  logic   res_valid;
  frame_t res;
  logic   out_valid_q, out_valid_d;
  frame_t frame_q, frame_d;

  // config writes never stall
  assign cfg_i.ready = 1'b1;

  lpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // room whenever the output register is empty or draining this cycle
  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign take       = rx_i.valid && rx_i.ready;

  lpd_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: load a new result, empty it once taken, else keep a stalled one
  always_comb begin
    frame_d = frame_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      frame_d     = res;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.out_byte     = frame_q.out_byte;
  assign tx_o.pkt_start    = frame_q.pkt_start;
  assign tx_o.pkt_end      = frame_q.pkt_end;
  assign tx_o.frame_status = frame_q.frame_status;

endmodule

[sv/lpd_checker.sv]
`timescale 1ns / 1ps

module lpd_checker
  import lpd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_start_i,
  input logic       tx_end_i,
  input logic [1:0] tx_status_i
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(tx_byte_i)
      && $stable(tx_start_i) && $stable(tx_end_i) && $stable(tx_status_i))
    else $error("stalled output beat changed");

  // an error beat closes the packet and never starts one
  a_err_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_status_i != ST_OK |-> tx_end_i && !tx_start_i
      && (tx_status_i == ST_SHORT || tx_status_i == ST_LONG))
    else $error("bad error beat");

  // a start beat carries a first header byte only
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_start_i |-> !tx_end_i && tx_status_i == ST_OK)
    else $error("bad start beat");

  // an accepted error beat is not directly followed by a valid beat
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_ready_i && tx_status_i != ST_OK |=> !tx_valid_i)
    else $error("output after error");

endmodule

bind length_prefixed_byte_deframer lpd_checker u_lpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tx_valid_i  (tx_o.valid),
  .tx_ready_i  (tx_o.ready),
  .tx_byte_i   (tx_o.out_byte),
  .tx_start_i  (tx_o.pkt_start),
  .tx_end_i    (tx_o.pkt_end),
  .tx_status_i (tx_o.frame_status)
);

[dv/length_prefixed_byte_deframer_test.sv]
`timescale 1ns / 1ps

// testbench for the length prefixed byte deframer
// a sequence of test tasks pushes bytes into rx_i; every accepted byte goes
// through a local copy of the framing state, which queues the beat that tx_o
// should give for it. one process on tx_o throttles ready at random and checks
// every accepted beat against the oldest queued one
// an out of bounds length closes the block until reset, and reset happens
// only once, so the bad length case runs last with a randomly picked flavor
module length_prefixed_byte_deframer_test;
  import lpd_pkg::*;

  // the two bit index field has one code with no register behind it
  localparam logic [1:0]  CFG_UNUSED_IDX  = 2'd3;
  // a taken byte passes the one output register before it shows, which this covers
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned TAIL_CYCLES     = 16;
  localparam int unsigned RANDOM_BYTES    = 1300;
  localparam int unsigned QUIET_BYTES     = 200;
  // long enough that the high header byte and the body count both matter
  localparam int unsigned LONG_PACKET_LEN = 300;
  // about 2k bytes, each at worst a full sender gap plus a full stall,
  // plus the drains around register writes
  localparam int unsigned CYCLE_LIMIT     = 400_000;

  logic clk_i;
  logic rst_ni;

  lpd_byte_if  rx_bus ();
  lpd_frame_if tx_bus ();
  lpd_cfg_if   cfg_bus ();

  length_prefixed_byte_deframer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .tx_o   (tx_bus),
    .cfg_i  (cfg_bus)
  );

  // local copy of the framing state and registers
  cfg_t        len_cfg;
  phase_e      frame_phase;
  logic [7:0]  hdr_first;
  logic [15:0] body_left;

  frame_t      expected_frames[$];
  int unsigned failures;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          rx_gaps_on;
  bit          tx_stalls_on;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic frame_t make_frame(input logic [7:0] b, input logic s, input logic e,
                                        input logic [1:0] st);
    frame_t f;
    f.out_byte     = b;
    f.pkt_start    = s;
    f.pkt_end      = e;
    f.frame_status = st;
    return f;
  endfunction

  task automatic reset_framing();
    len_cfg.min_len    = MIN_LEN_DEFAULT;
    len_cfg.max_len    = MAX_LEN_DEFAULT;
    len_cfg.big_endian = 1'b0;
    frame_phase        = PH_IDLE;
    hdr_first          = 8'd0;
    body_left          = 16'd0;
  endtask

  // advance the framing state by one received byte and queue its beat
  task automatic frame_byte(input logic [7:0] b);
    logic [15:0] total_len;
    case (frame_phase)
      PH_IDLE: begin
        // the first header byte goes out before the length is known
        hdr_first   = b;
        frame_phase = PH_LEN2;
        expected_frames.push_back(make_frame(b, 1'b1, 1'b0, ST_OK));
      end
      PH_LEN2: begin
        total_len = len_cfg.big_endian ? {hdr_first, b} : {b, hdr_first};
        // a length shorter than its own header is always too short, and
        // too short wins over too long when the bounds cross
        if (total_len < LEN_HDR_BYTES || total_len < len_cfg.min_len) begin
          frame_phase = PH_CLOSED;
          expected_frames.push_back(make_frame(b, 1'b0, 1'b1, ST_SHORT));
        end else if (total_len > len_cfg.max_len) begin
          frame_phase = PH_CLOSED;
          expected_frames.push_back(make_frame(b, 1'b0, 1'b1, ST_LONG));
        end else begin
          body_left = total_len - LEN_HDR_BYTES;
          if (body_left == 16'd0) begin
            // header only packet ends on its second byte
            frame_phase = PH_IDLE;
            expected_frames.push_back(make_frame(b, 1'b0, 1'b1, ST_OK));
          end else begin
            frame_phase = PH_BODY;
            expected_frames.push_back(make_frame(b, 1'b0, 1'b0, ST_OK));
          end
        end
      end
      PH_BODY: begin
        if (body_left <= 16'd1) begin
          body_left   = 16'd0;
          frame_phase = PH_IDLE;
          expected_frames.push_back(make_frame(b, 1'b0, 1'b1, ST_OK));
        end else begin
          body_left = body_left - 16'd1;
          expected_frames.push_back(make_frame(b, 1'b0, 1'b0, ST_OK));
        end
      end
      default: begin
        // closed: byte is swallowed, nothing comes out
      end
    endcase
  endtask

  // one rx beat, with an optional gap in front of it
  // valid stays high on return so back to back bytes need no extra edge
  task automatic send_byte(input logic [7:0] b);
    if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
      rx_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    frame_byte(b);
    do @(posedge clk_i); while (!rx_bus.ready);
    bytes_sent++;
  endtask

  // hold rx off until every queued beat has come out, then let the pipe settle
  task automatic wait_drained();
    rx_bus.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register writes only go in while the block has nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_LEN:    len_cfg.min_len    = val;
      CFG_MAX_LEN:    len_cfg.max_len    = val;
      CFG_BIG_ENDIAN: len_cfg.big_endian = val[0];
      default: begin
        // unused index, no register changes
      end
    endcase
  endtask

  task automatic send_header(input int unsigned total_len);
    logic [15:0] l;
    l = 16'(total_len);
    if (len_cfg.big_endian) begin
      send_byte(l[15:8]);
      send_byte(l[7:0]);
    end else begin
      send_byte(l[7:0]);
      send_byte(l[15:8]);
    end
  endtask

  // header in the current byte order, then a random body
  task automatic send_packet(input int unsigned total_len);
    int unsigned i;
    send_header(total_len);
    for (i = 2; i < total_len; i++) send_byte(8'($urandom));
  endtask

  // defaults after reset: header only packet and a body with extreme bytes
  task automatic test_reset_defaults();
    send_packet(2);
    send_header(6);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
  endtask

  // big endian header, then registers rewritten in the middle of a packet;
  // the packet in flight keeps its decoded length
  task automatic test_byte_order();
    write_reg(CFG_BIG_ENDIAN, 16'd1);
    send_packet(3);
    write_reg(CFG_BIG_ENDIAN, 16'd0);
    send_header(5);
    send_byte(8'h81);
    write_reg(CFG_MAX_LEN, 16'd3);
    write_reg(CFG_BIG_ENDIAN, 16'd1);
    send_byte(8'h7E);
    send_byte(8'hC3);
    // next decode uses the new order and bound
    send_packet(3);
    write_reg(CFG_MAX_LEN, MAX_LEN_DEFAULT);
    write_reg(CFG_BIG_ENDIAN, 16'd0);
  endtask

  // bounds that meet, the lowest legal maximum, and the unused index
  task automatic test_bounds();
    write_reg(CFG_MIN_LEN, 16'd4);
    write_reg(CFG_MAX_LEN, 16'd4);
    send_packet(4);
    write_reg(CFG_MIN_LEN, 16'd2);
    write_reg(CFG_MAX_LEN, 16'd2);
    send_packet(2);
    write_reg(CFG_MAX_LEN, MAX_LEN_DEFAULT);
    // would flip the byte order if the index decode were sloppy
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_packet(3);
  endtask

  // one long packet with both bounds pinned to its length,
  // no idling so it stays quick
  task automatic test_longest_packet();
    rx_gaps_on   = 1'b0;
    tx_stalls_on = 1'b0;
    write_reg(CFG_MIN_LEN, 16'(LONG_PACKET_LEN));
    write_reg(CFG_MAX_LEN, 16'(LONG_PACKET_LEN));
    send_packet(LONG_PACKET_LEN);
    write_reg(CFG_MIN_LEN, MIN_LEN_DEFAULT);
    write_reg(CFG_MAX_LEN, MAX_LEN_DEFAULT);
    rx_gaps_on   = 1'b1;
    tx_stalls_on = 1'b1;
  endtask

  task automatic pick_random_bounds();
    int unsigned lo;
    int unsigned hi;
    lo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(2, 40);
    case ($urandom_range(0, 3))
      0:       hi = lo;
      1:       hi = 65535;
      default: hi = $urandom_range(lo, lo + 200);
    endcase
    write_reg(CFG_MIN_LEN, 16'(lo));
    write_reg(CFG_MAX_LEN, 16'(hi));
    write_reg(CFG_BIG_ENDIAN, 16'($urandom_range(0, 1)));
  endtask

  // legal packets with random bodies, mostly short, now and then a few hundred
  // bytes; bounds change between packets; the tail runs with no idling
  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned quiet_at;
    int unsigned cap;
    int unsigned total_len;
    stop_at  = bytes_sent + RANDOM_BYTES;
    quiet_at = stop_at - QUIET_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) pick_random_bounds();
      else if ($urandom_range(0, 15) == 0) wait_drained();
      rx_gaps_on   = bytes_sent < quiet_at;
      tx_stalls_on = bytes_sent < quiet_at;
      cap = len_cfg.min_len + (($urandom_range(0, 9) == 0) ? 400 : 12);
      if (cap > len_cfg.max_len) cap = len_cfg.max_len;
      total_len = $urandom_range(len_cfg.min_len, cap);
      send_packet(total_len);
    end
  endtask

  // one bad length closes the block for good, so one flavor per run:
  // below min, above max, shorter than the header, or crossed bounds
  task automatic test_bad_length();
    int unsigned lo;
    int unsigned hi;
    int unsigned total_len;
    int unsigned i;
    rx_gaps_on   = 1'b0;
    tx_stalls_on = 1'b0;
    write_reg(CFG_BIG_ENDIAN, 16'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: begin
        lo = $urandom_range(3, 1000);
        write_reg(CFG_MIN_LEN, 16'(lo));
        total_len = $urandom_range(2, lo - 1);
      end
      1: begin
        hi = $urandom_range(2, 65534);
        write_reg(CFG_MAX_LEN, 16'(hi));
        total_len = $urandom_range(hi + 1, 65535);
      end
      2: begin
        write_reg(CFG_MIN_LEN, 16'd0);
        total_len = $urandom_range(0, 1);
      end
      default: begin
        lo = $urandom_range(100, 65535);
        hi = $urandom_range(2, lo - 1);
        write_reg(CFG_MIN_LEN, 16'(lo));
        write_reg(CFG_MAX_LEN, 16'(hi));
        total_len = $urandom_range(0, 65535);
      end
    endcase
    send_header(total_len);
    // everything after the error must vanish
    for (i = $urandom_range(3, 20); i != 0; i--) send_byte(8'($urandom));
  endtask

  // tx side: random stalls and the beat by beat compare
  always @(posedge clk_i) begin : frame_check
    frame_t want;
    if (rst_ni && tx_bus.valid && tx_bus.ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected beat: out_byte %h", tx_bus.out_byte);
        failures++;
      end else begin
        want = expected_frames.pop_front();
        if (tx_bus.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, tx_bus.out_byte);
          failures++;
        end
        if (tx_bus.pkt_start !== want.pkt_start) begin
          $error("pkt_start: expected %b, got %b", want.pkt_start, tx_bus.pkt_start);
          failures++;
        end
        if (tx_bus.pkt_end !== want.pkt_end) begin
          $error("pkt_end: expected %b, got %b", want.pkt_end, tx_bus.pkt_end);
          failures++;
        end
        if (tx_bus.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status,
                 tx_bus.frame_status);
          failures++;
        end
      end
    end
    if (!rst_ni) begin
      tx_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      tx_bus.ready <= 1'b0;
    end else if (tx_stalls_on && $urandom_range(0, 4) == 0) begin
      // stall now, then keep stalling while stall_left counts down
      stall_left = $urandom_range(0, 10);
      tx_bus.ready <= 1'b0;
    end else begin
      tx_bus.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    rx_bus.valid    = 1'b0;
    rx_bus.rx_byte  = 8'd0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_MIN_LEN;
    cfg_bus.data    = 16'd0;
    tx_bus.ready    = 1'b0;
    failures        = 0;
    bytes_sent      = 0;
    cycle_count     = 0;
    stall_left      = 0;
    rx_gaps_on      = 1'b1;
    tx_stalls_on    = 1'b1;
    reset_framing();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_byte_order();
    test_bounds();
    test_longest_packet();
    test_random_traffic();
    test_bad_length();

    // let the last beats out, then watch a while for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (expected_frames.size() != 0) begin
        $error("%0d expected beats never came out", expected_frames.size());
      end
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
